@@ hw/rtl/bmse_pkg.sv @@
// ----------------------------------------------------------------------------
// bmse_pkg
// Shared widths, controller states and the command/status bundles between
// the binned mean controller and its datapath.
// ----------------------------------------------------------------------------
package bmse_pkg;

	localparam int BIN_W  = 16;
	localparam int SUM_W  = 48;
	localparam int ACC_W  = 64;
	localparam int MEAN_W = 32;
	localparam int SE_W   = 31;
	localparam int BINS_W = 32;
	localparam int ROOT_W = 32;

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_CHECK,
		ST_BDIV,
		ST_BDIV_W,
		ST_BSQ,
		ST_BACC,
		ST_FIN,
		ST_MDIV,
		ST_MDIV_W,
		ST_MSQ,
		ST_QDIV,
		ST_QDIV_W,
		ST_VAR,
		ST_VDIV,
		ST_VDIV_W,
		ST_SQRT,
		ST_SQRT_W,
		ST_RES
	} state_t;

	typedef enum logic [1:0] {
		DIV_BIN,
		DIV_MEAN,
		DIV_MSQ,
		DIV_VAR
	} div_op_t;

	typedef struct packed {
		logic    in_ready;
		logic    div_start;
		div_op_t div_op;
		logic    sq_load;
		logic    mean_load;
		logic    bin_commit;
		logic    var_load;
		logic    sqrt_start;
		logic    out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic accepted;
		logic close;
		logic last;
		logic err;
		logic div_done;
		logic sqrt_done;
		logic out_busy;
	} dp_sts_t;

endpackage

@@ hw/rtl/bmse_in_if.sv @@
// ----------------------------------------------------------------------------
// bmse_in_if
// Sample channel: valid/ready with a sample and a last flag.
// ----------------------------------------------------------------------------
interface bmse_in_if #(
	parameter int SAMPLE_WIDTH = 32
);
	logic                    valid;
	logic                    ready;
	logic [SAMPLE_WIDTH-1:0] sample;
	logic                    last;

	modport source (output valid, output sample, output last, input ready);
	modport sink   (input valid, input sample, input last, output ready);
endinterface

@@ hw/rtl/bmse_out_if.sv @@
// ----------------------------------------------------------------------------
// bmse_out_if
// Result channel: valid/ready with mean, standard error, bin count, status.
// ----------------------------------------------------------------------------
interface bmse_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] mean;
	logic [30:0] std_error;
	logic [31:0] bins_used;
	logic        status;

	modport source (output valid, output mean, output std_error, output bins_used,
		output status, input ready);
	modport sink   (input valid, input mean, input std_error, input bins_used,
		input status, output ready);
endinterface

@@ hw/rtl/binned_mean_std_error.sv @@
// ----------------------------------------------------------------------------
// binned_mean_std_error
// Binned mean and standard error of a Q16.16 sample stream.
// ----------------------------------------------------------------------------
// A sample that closes a bin waits for the 64-step serial divider that forms
// the bin average. Unless the data set is in error, the sample marked last
// adds three passes through that divider and 32 steps of the serial square
// root unit. The result waits in an output register, and the next data set
// is taken in while it waits. The bin length is to be written only while no
// sample is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module binned_mean_std_error
	import bmse_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [BIN_W-1:0] cfg_wdata,
	bmse_in_if.sink          samples,
	bmse_out_if.source       results
);
	dp_cmd_t cmd;
	dp_sts_t sts;

	assign samples.ready = cmd.in_ready;

	bmse_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	bmse_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COUNT_WIDTH  (COUNT_WIDTH)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.sts           (sts),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (samples.valid),
		.in_sample     (samples.sample),
		.in_last       (samples.last),
		.out_ready     (results.ready),
		.out_valid     (results.valid),
		.out_mean      (results.mean),
		.out_std_error (results.std_error),
		.out_bins_used (results.bins_used),
		.out_status    (results.status)
	);

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(results.valid && !results.ready))
		else $error("result loaded over a pending result");

	a_load_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |=> results.valid)
		else $error("loaded result not presented");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.status) |-> (results.mean == '0 && results.std_error == '0))
		else $error("error result carries nonzero statistics");
`endif
endmodule

@@ hw/rtl/bmse_div.sv @@
// ----------------------------------------------------------------------------
// bmse_div
// Restoring unsigned divider, one quotient bit per cycle, 64-bit dividend.
// ----------------------------------------------------------------------------
module bmse_div
	import bmse_pkg::*;
#(
	parameter int DIV_W = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [ACC_W-1:0] dividend,
	input  logic [DIV_W-1:0] divisor,
	output logic [ACC_W-1:0] quotient,
	output logic             done
);
	localparam int CNT_W = $clog2(ACC_W);

	logic [ACC_W-1:0] acc_q;
	logic [DIV_W-1:0] rem_q;
	logic [DIV_W-1:0] dsr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DIV_W:0]   trial;
	logic             fits;

	assign trial = {rem_q, acc_q[ACC_W-1]};
	assign fits  = trial >= {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= dividend;
			rem_q <= '0;
			dsr_q <= divisor;
		end else if (busy_q) begin
			acc_q <= {acc_q[ACC_W-2:0], fits};
			rem_q <= fits ? DIV_W'(trial - {1'b0, dsr_q}) : trial[DIV_W-1:0];
		end
	end

	assign quotient = acc_q;
	assign done     = done_q;
endmodule

@@ hw/rtl/bmse_sqrt.sv @@
// ----------------------------------------------------------------------------
// bmse_sqrt
// Digit-by-digit integer square root of a 64-bit value, one root bit a cycle.
// ----------------------------------------------------------------------------
module bmse_sqrt
	import bmse_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [ACC_W-1:0]  radicand,
	output logic [ROOT_W-1:0] root,
	output logic              done
);
	localparam int CNT_W = $clog2(ROOT_W);
	localparam int REM_W = ROOT_W + 4;

	logic [ACC_W-1:0]  val_q;
	logic [REM_W-3:0]  rem_q;
	logic [ROOT_W-1:0] root_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              busy_q;
	logic              done_q;
	logic [REM_W-1:0]  part;
	logic [REM_W-1:0]  trial;
	logic              fits;

	assign part  = {rem_q, val_q[ACC_W-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign fits  = part >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (&cnt_q) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			val_q  <= {val_q[ACC_W-3:0], 2'b00};
			rem_q  <= fits ? (REM_W-2)'(part - trial) : part[REM_W-3:0];
			root_q <= {root_q[ROOT_W-2:0], fits};
		end
	end

	assign root = root_q;
	assign done = done_q;
endmodule

@@ hw/rtl/bmse_ctrl.sv @@
// ----------------------------------------------------------------------------
// bmse_ctrl
// Sequencer: sample intake, bin close, and the final mean / error pass.
// ----------------------------------------------------------------------------
module bmse_ctrl
	import bmse_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);
	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				if (sts.accepted) state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (sts.close)     state_d = ST_BDIV;
				else if (sts.last) state_d = ST_FIN;
				else               state_d = ST_IDLE;
			end
			ST_BDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_BIN;
				state_d       = ST_BDIV_W;
			end
			ST_BDIV_W: begin
				if (sts.div_done) state_d = ST_BSQ;
			end
			ST_BSQ: begin
				cmd.sq_load = 1'b1;
				state_d     = ST_BACC;
			end
			ST_BACC: begin
				cmd.bin_commit = 1'b1;
				state_d        = sts.last ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				state_d = sts.err ? ST_RES : ST_MDIV;
			end
			ST_MDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_MEAN;
				state_d       = ST_MDIV_W;
			end
			ST_MDIV_W: begin
				if (sts.div_done) state_d = ST_MSQ;
			end
			ST_MSQ: begin
				cmd.sq_load   = 1'b1;
				cmd.mean_load = 1'b1;
				state_d       = ST_QDIV;
			end
			ST_QDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_MSQ;
				state_d       = ST_QDIV_W;
			end
			ST_QDIV_W: begin
				if (sts.div_done) state_d = ST_VAR;
			end
			ST_VAR: begin
				cmd.var_load = 1'b1;
				state_d      = ST_VDIV;
			end
			ST_VDIV: begin
				cmd.div_start = 1'b1;
				cmd.div_op    = DIV_VAR;
				state_d       = ST_VDIV_W;
			end
			ST_VDIV_W: begin
				if (sts.div_done) state_d = ST_SQRT;
			end
			ST_SQRT: begin
				cmd.sqrt_start = 1'b1;
				state_d        = ST_SQRT_W;
			end
			ST_SQRT_W: begin
				if (sts.sqrt_done) state_d = ST_RES;
			end
			ST_RES: begin
				// hold until the output register is free
				if (!sts.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end
endmodule

@@ hw/rtl/bmse_dp.sv @@
// ----------------------------------------------------------------------------
// bmse_dp
// Datapath: bin accumulator, running totals, shared divider, multiplier,
// square root unit and the result register.
// ----------------------------------------------------------------------------
module bmse_dp
	import bmse_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 32,
	parameter int COUNT_WIDTH  = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  dp_cmd_t                 cmd,
	output dp_sts_t                 sts,
	input  logic                    cfg_we,
	input  logic [BIN_W-1:0]        cfg_wdata,
	input  logic                    in_valid,
	input  logic [SAMPLE_WIDTH-1:0] in_sample,
	input  logic                    in_last,
	input  logic                    out_ready,
	output logic                    out_valid,
	output logic [MEAN_W-1:0]       out_mean,
	output logic [SE_W-1:0]         out_std_error,
	output logic [BINS_W-1:0]       out_bins_used,
	output logic                    out_status
);
	localparam int DIV_W = (COUNT_WIDTH > BIN_W) ? COUNT_WIDTH : BIN_W;

	logic [BIN_W-1:0]        bin_len_q;
	logic signed [SUM_W-1:0] bin_sum_q;
	logic [BIN_W-1:0]        cnt_q;
	logic [COUNT_WIDTH-1:0]  bins_q;
	logic signed [ACC_W-1:0] avg_tot_q;
	logic [ACC_W-1:0]        sq_tot_q;
	logic [ACC_W-1:0]        sq_q;
	logic signed [ACC_W-1:0] mean_q;
	logic [ACC_W-1:0]        var_q;
	logic                    last_q;

	logic                    out_valid_q;
	logic [MEAN_W-1:0]       out_mean_q;
	logic [SE_W-1:0]         out_se_q;
	logic [BINS_W-1:0]       out_bins_q;
	logic                    out_status_q;

	logic                    accept;
	logic [BIN_W-1:0]        bs;
	logic signed [SUM_W:0]   sum_x;
	logic [SUM_W-1:0]        sum_sat;
	logic [SUM_W-1:0]        bin_mag;
	logic [ACC_W-1:0]        avg_mag;
	logic [ACC_W-1:0]        div_dividend;
	logic [DIV_W-1:0]        div_divisor;
	logic [ACC_W-1:0]        div_q;
	logic                    div_done;
	logic [ROOT_W-1:0]       root;
	logic                    sqrt_done;
	logic [ROOT_W-1:0]       sq_in;
	logic [ACC_W-1:0]        prod;
	logic [ACC_W-1:0]        sq_next;
	logic [ACC_W-1:0]        avg_val;
	logic [ACC_W:0]          tot_x;
	logic [ACC_W-1:0]        tot_sat;
	logic [ACC_W:0]          sqt_x;
	logic [ACC_W-1:0]        sqt_sat;
	logic [COUNT_WIDTH-1:0]  bins_next;
	logic                    err;
	logic                    mean_fits;
	logic [MEAN_W-1:0]       mean_sat;
	logic [SE_W-1:0]         se_sat;
	logic [BINS_W-1:0]       bins_sat;

	assign accept = in_valid & cmd.in_ready;
	assign bs     = (bin_len_q == '0) ? BIN_W'(1) : bin_len_q;

	// saturating bin accumulate
	assign sum_x   = {bin_sum_q[SUM_W-1], bin_sum_q}
		+ (SUM_W+1)'($signed(in_sample));
	assign sum_sat = (sum_x[SUM_W] != sum_x[SUM_W-1])
		? {sum_x[SUM_W], {(SUM_W-1){~sum_x[SUM_W]}}} : sum_x[SUM_W-1:0];

	assign bin_mag = bin_sum_q[SUM_W-1] ? SUM_W'(-bin_sum_q) : SUM_W'(bin_sum_q);
	assign avg_mag = avg_tot_q[ACC_W-1] ? ACC_W'(-avg_tot_q) : ACC_W'(avg_tot_q);

	always_comb begin
		case (cmd.div_op)
			DIV_BIN: begin
				div_dividend = ACC_W'(bin_mag);
				div_divisor  = DIV_W'(bs);
			end
			DIV_MEAN: begin
				div_dividend = avg_mag;
				div_divisor  = DIV_W'(bins_q);
			end
			DIV_MSQ: begin
				div_dividend = sq_tot_q;
				div_divisor  = DIV_W'(bins_q);
			end
			DIV_VAR: begin
				div_dividend = var_q;
				div_divisor  = DIV_W'(bins_q);
			end
			default: begin
				div_dividend = '0;
				div_divisor  = '0;
			end
		endcase
	end

	bmse_div #(.DIV_W(DIV_W)) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.quotient (div_q),
		.done     (div_done)
	);

	bmse_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.sqrt_start),
		.radicand (div_q),
		.root     (root),
		.done     (sqrt_done)
	);

	// saturating square of a quotient magnitude
	assign sq_in   = div_q[ROOT_W-1:0];
	assign prod    = sq_in * sq_in;
	assign sq_next = (|div_q[ACC_W-1:ROOT_W]) ? '1 : prod;

	assign avg_val   = bin_sum_q[SUM_W-1] ? ACC_W'(-div_q) : div_q;
	assign tot_x     = {avg_tot_q[ACC_W-1], avg_tot_q} + {avg_val[ACC_W-1], avg_val};
	assign tot_sat   = (tot_x[ACC_W] != tot_x[ACC_W-1])
		? {tot_x[ACC_W], {(ACC_W-1){~tot_x[ACC_W]}}} : tot_x[ACC_W-1:0];
	assign sqt_x     = {1'b0, sq_tot_q} + {1'b0, sq_q};
	assign sqt_sat   = sqt_x[ACC_W] ? '1 : sqt_x[ACC_W-1:0];
	assign bins_next = (&bins_q) ? bins_q : bins_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bin_len_q  <= BIN_W'(1);
			bin_sum_q  <= '0;
			cnt_q      <= '0;
			bins_q     <= '0;
			avg_tot_q  <= '0;
			sq_tot_q   <= '0;
			last_q     <= 1'b0;
		end else begin
			if (cfg_we) bin_len_q <= cfg_wdata;
			if (accept) begin
				bin_sum_q <= sum_sat;
				cnt_q     <= cnt_q + 1'b1;
				last_q    <= in_last;
			end
			if (cmd.bin_commit) begin
				avg_tot_q <= tot_sat;
				sq_tot_q  <= sqt_sat;
				bins_q    <= bins_next;
				bin_sum_q <= '0;
				cnt_q     <= '0;
			end
			// clear the data set once its result is loaded into the output register
			if (cmd.out_load) begin
				bin_sum_q <= '0;
				cnt_q     <= '0;
				bins_q    <= '0;
				avg_tot_q <= '0;
				sq_tot_q  <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sq_load)   sq_q   <= sq_next;
		if (cmd.mean_load) mean_q <= avg_tot_q[ACC_W-1] ? ACC_W'(-div_q) : div_q;
		if (cmd.var_load)  var_q  <= (div_q > sq_q) ? div_q - sq_q : '0;
	end

	assign err       = (cnt_q != '0) || (bins_q == '0);
	assign mean_fits = mean_q[ACC_W-1:MEAN_W-1] == {(ACC_W-MEAN_W+1){mean_q[MEAN_W-1]}};
	assign mean_sat  = mean_fits ? mean_q[MEAN_W-1:0]
		: {mean_q[ACC_W-1], {(MEAN_W-1){~mean_q[ACC_W-1]}}};
	assign se_sat    = root[ROOT_W-1] ? '1 : root[SE_W-1:0];

	generate
		if (COUNT_WIDTH > BINS_W) begin : g_bins_wide
			assign bins_sat = (|bins_q[COUNT_WIDTH-1:BINS_W]) ? '1 : bins_q[BINS_W-1:0];
		end else begin : g_bins_narrow
			assign bins_sat = BINS_W'(bins_q);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_mean_q   <= err ? '0 : mean_sat;
			out_se_q     <= err ? '0 : se_sat;
			out_bins_q   <= bins_sat;
			out_status_q <= err;
		end
	end

	assign out_valid     = out_valid_q;
	assign out_mean      = out_mean_q;
	assign out_std_error = out_se_q;
	assign out_bins_used = out_bins_q;
	assign out_status    = out_status_q;

	assign sts.accepted  = accept;
	assign sts.close     = (cnt_q >= bs) || (cnt_q == '0);
	assign sts.last      = last_q;
	assign sts.err       = err;
	assign sts.div_done  = div_done;
	assign sts.sqrt_done = sqrt_done;
	assign sts.out_busy  = out_valid_q & ~out_ready;
endmodule

@@ dv/binned_mean_std_error_test.sv @@
// ----------------------------------------------------------------------------
// binned_mean_std_error_test
// Sends signed Q16.16 sample streams through the binned mean unit under
// several bin sizes. A predictor, advanced per accepted sample, computes the
// expected mean, standard error, bin count and status of each data set. Each
// result is compared field by field as it leaves, with random gaps and stalls
// on both channels.
// ----------------------------------------------------------------------------
module binned_mean_std_error_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bmse_pkg::*;

	localparam longint BIN_HI  = 64'sh0000_7FFF_FFFF_FFFF;
	localparam longint BIN_LO  = -64'sh0000_8000_0000_0000;
	localparam int     SETTLE  = 400;
	localparam int     LIMIT   = 2000000;
	localparam int     TARGET  = 850;

	typedef struct {
		logic [31:0] mean;
		logic [30:0] std_error;
		logic [31:0] bins_used;
		logic        status;
	} summary_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [BIN_W-1:0] cfg_wdata;

	bmse_in_if #(.SAMPLE_WIDTH(32)) smp ();
	bmse_out_if res ();

	binned_mean_std_error dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.samples(smp), .results(res)
	);

	// predictor state
	logic [15:0]  bin_len_q;
	longint       open_sum;
	logic [15:0]  open_count;
	logic [31:0]  bins_closed;
	longint       avg_total;
	logic [63:0]  sq_total;

	summary_t     pending[$];
	int           errors;
	int           sent_items;
	int           sets_sent;
	int           results_seen;
	int           bad_sets;
	int           burst_left;
	longint       cycles;

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("end of test: mismatches");
			$finish;
		end
	end

	function automatic logic [63:0] square_of(input longint v);
		logic [63:0] m;
		m = v < 0 ? 64'd0 - 64'(v) : 64'(v);
		if (m[63:32] != 0)
			return '1;
		return m * m;
	endfunction

	function automatic longint add_clamped(input longint a, input longint b);
		logic signed [64:0] t;
		t = {a[63], a} + {b[63], b};
		if (t > 65'sh0_7FFF_FFFF_FFFF_FFFF)
			return 64'sh7FFF_FFFF_FFFF_FFFF;
		if (t < -65'sh0_8000_0000_0000_0000)
			return 64'sh8000_0000_0000_0000;
		return t[63:0];
	endfunction

	function automatic logic [63:0] int_sqrt(input logic [63:0] v);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > v)
			bitv >>= 2;
		while (bitv != 0) begin
			if (v >= root + bitv) begin
				v -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	function automatic void clear_stats();
		open_sum = 0;
		open_count = 0;
		bins_closed = 0;
		avg_total = 0;
		sq_total = 0;
	endfunction

	// advance the predictor by one accepted sample
	function automatic bit accumulate_sample(input logic [31:0] s, input logic lst,
			output summary_t r);
		longint bs, avg, mean64, ms;
		logic [63:0] sq, n, msq, m2, var_q, se;
		bs = bin_len_q == 0 ? 1 : longint'(bin_len_q);
		open_sum += longint'($signed(s));
		if (open_sum > BIN_HI)
			open_sum = BIN_HI;
		if (open_sum < BIN_LO)
			open_sum = BIN_LO;
		open_count = open_count + 16'd1;
		if (longint'(open_count) >= bs || open_count == 0) begin
			avg = open_sum / bs;
			sq = square_of(avg);
			avg_total = add_clamped(avg_total, avg);
			sq_total = (sq_total > ~sq) ? '1 : sq_total + sq;
			if (bins_closed != '1)
				bins_closed++;
			open_sum = 0;
			open_count = 0;
		end
		if (!lst)
			return 0;
		r.mean = 0;
		r.std_error = 0;
		r.status = 0;
		r.bins_used = bins_closed;
		n = {32'd0, bins_closed};
		if (open_count != 0 || n == 0) begin
			r.status = 1;
		end else begin
			mean64 = avg_total / longint'(n);
			msq = sq_total / n;
			m2 = square_of(mean64);
			var_q = msq > m2 ? msq - m2 : 0;
			se = int_sqrt(var_q / n);
			ms = mean64;
			if (ms > 64'sd2147483647)
				ms = 64'sd2147483647;
			if (ms < -64'sd2147483648)
				ms = -64'sd2147483648;
			r.mean = ms[31:0];
			r.std_error = se > 64'h7FFF_FFFF ? 31'h7FFF_FFFF : se[30:0];
		end
		clear_stats();
		return 1;
	endfunction

	task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
		$display("MISMATCH %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
		errors++;
	endtask

	// result checker
	always @(posedge clk) begin
		summary_t w;
		if (arst_n && res.valid && res.ready) begin
			results_seen++;
			if (pending.size() == 0) begin
				report("unexpected result", res.mean, 0);
			end else begin
				w = pending.pop_front();
				if (res.mean !== w.mean)
					report("mean", res.mean, w.mean);
				if (res.std_error !== w.std_error)
					report("std_error", res.std_error, w.std_error);
				if (res.bins_used !== w.bins_used)
					report("bins_used", res.bins_used, w.bins_used);
				if (res.status !== w.status)
					report("status", res.status, w.status);
			end
		end
	end

	// receiver stall pattern in four modes, redrawn at random
	initial begin
		int mode;
		res.ready = 0;
		mode = 0;
		forever begin
			@(negedge clk);
			if (cycles % 64 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: res.ready = 1;
				1: res.ready = $urandom_range(0, 1);
				2: res.ready = ($urandom_range(0, 7) == 0);
				default: res.ready = (cycles % 5) != 0;
			endcase
		end
	end

	task automatic send_sample(input logic [31:0] s, input logic lst);
		summary_t r;
		@(negedge clk);
		if (burst_left == 0) begin
			smp.valid = 0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		burst_left--;
		smp.valid = 1;
		smp.sample = s;
		smp.last = lst;
		do @(posedge clk); while (!smp.ready);
		sent_items++;
		if (lst)
			sets_sent++;
		if (accumulate_sample(s, lst, r)) begin
			if (r.status)
				bad_sets++;
			pending.push_back(r);
		end
	endtask

	task automatic hold_input();
		@(negedge clk);
		smp.valid = 0;
	endtask

	task automatic drain();
		hold_input();
		while (pending.size() != 0)
			@(posedge clk);
	endtask

	task automatic set_bin_len(input logic [15:0] v);
		drain();
		repeat (SETTLE) @(posedge clk);
		@(negedge clk);
		cfg_we = 1;
		cfg_wdata = v;
		@(posedge clk);
		bin_len_q = v;
		@(negedge clk);
		cfg_we = 0;
	endtask

	function automatic logic [31:0] pick_sample();
		case ($urandom_range(0, 5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(0, 65535) - 32768;
			default: return $urandom;
		endcase
	endfunction

	// one data set of whole bins, optionally with a trailing partial bin
	task automatic send_set(input int nbins, input bit ragged);
		int bs, len;
		bs = bin_len_q == 0 ? 1 : bin_len_q;
		len = nbins * bs;
		if (ragged && bs > 1)
			len += $urandom_range(1, bs - 1);
		else if (ragged)
			len = 0;
		if (len == 0)
			len = 1;
		for (int i = 0; i < len; i++)
			send_sample(pick_sample(), i == len - 1);
	endtask

	task automatic test_field_extremes();
		set_bin_len(1);
		send_sample(32'h7FFF_FFFF, 0);
		send_sample(32'h8000_0000, 0);
		send_sample(32'h0000_0000, 0);
		send_sample(32'hFFFF_FFFF, 1);
		send_sample(32'h0001_0000, 1);
	endtask

	task automatic test_square_saturation();
		for (int i = 0; i < 5; i++)
			send_sample(32'h8000_0000, i == 4);
		for (int i = 0; i < 4; i++)
			send_sample(i[0] ? 32'h7FFF_FFFF : 32'h8000_0000, i == 3);
	endtask

	task automatic test_zero_bin_size();
		set_bin_len(0);
		send_sample(32'h0003_0000, 0);
		send_sample(32'hFFFD_0000, 1);
	endtask

	task automatic test_count_error();
		set_bin_len(3);
		for (int i = 0; i < 4; i++)
			send_sample(32'h0001_8000 * i, i == 3);
		send_sample(32'h1234_5678, 1);
		set_bin_len(16'hFFFF);
		for (int i = 0; i < 5; i++)
			send_sample(pick_sample(), i == 4);
	endtask

	task automatic test_bin_change_midbin();
		set_bin_len(4);
		for (int i = 0; i < 3; i++)
			send_sample(32'h0002_0000, 0);
		// shrink the bin while it is open: next sample closes it
		set_bin_len(2);
		send_sample(32'h0002_0000, 0);
		send_sample(32'hFFFF_0000, 0);
		send_sample(32'h0005_0000, 1);
	endtask

	task automatic test_random_sets();
		logic [15:0] sizes[7] = '{16'd1, 16'd2, 16'd3, 16'd5, 16'd8, 16'd0, 16'd13};
		int base;
		base = sent_items;
		while (sent_items - base < TARGET) begin
			if ($urandom_range(0, 9) == 0)
				set_bin_len(sizes[$urandom_range(0, 6)]);
			send_set($urandom_range(1, 6), $urandom_range(0, 7) == 0);
			if ($urandom_range(0, 9) == 0)
				drain();
		end
	endtask

	initial begin
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		smp.valid = 0;
		smp.sample = 0;
		smp.last = 0;
		cycles = 0;
		errors = 0;
		sent_items = 0;
		sets_sent = 0;
		results_seen = 0;
		bad_sets = 0;
		burst_left = 0;
		bin_len_q = 1;
		clear_stats();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1;

		test_field_extremes();
		test_square_saturation();
		test_zero_bin_size();
		test_count_error();
		test_bin_change_midbin();
		test_random_sets();

		drain();
		repeat (SETTLE) @(posedge clk);
		$display("covered %0d samples in %0d data sets, %0d results, %0d with count errors",
			sent_items, sets_sent, results_seen, bad_sets);
		if (errors == 0 && pending.size() == 0) begin
			$display("end of test: clean");
		end else begin
			$display("%0d mismatches, %0d results missing", errors, pending.size());
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
